/* hw/rtl/priority_job_scheduler_with_aging_top_defines.svh */
// Assertion macros shared by the checker of the job scheduler.
`ifndef PRIORITY_JOB_SCHEDULER_WITH_AGING_TOP_DEFINES_SVH
`define PRIORITY_JOB_SCHEDULER_WITH_AGING_TOP_DEFINES_SVH
// An implication that must hold at every clock edge outside reset.
`define PJS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// An implication whose consequent must hold in the cycle after its antecedent.
`define PJS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hw/rtl/pjs_pkg.sv */
// ---------------------------------------------------------------------------
// pjs_pkg
// Types, constants and the cell state record of the job scheduler.
// ---------------------------------------------------------------------------
`default_nettype none
package pjs_pkg;
    localparam int QueueDepth = 16;
    localparam int IdBits     = 16;
    localparam int IdxBits    = $clog2(QueueDepth);
    localparam int LenBits    = $clog2(QueueDepth + 1);

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_ENQUEUE = 2'd1;
    localparam logic [1:0] OP_DEQUEUE = 2'd2;
    localparam logic [1:0] OP_DONE    = 2'd3;

    localparam logic [2:0] REG_QUANTUM1 = 3'd0;
    localparam logic [2:0] REG_QUANTUM2 = 3'd1;
    localparam logic [2:0] REG_QUANTUM3 = 3'd2;
    localparam logic [2:0] REG_AGE_LIM  = 3'd3;
    localparam logic [2:0] REG_AGE_CEIL = 3'd4;

    typedef struct packed {
        logic [1:0]        op;
        logic [2:0]        priority_req;
        logic [IdBits-1:0] target_job;
    } in_word_t;

    typedef struct packed {
        logic              running_valid;
        logic [IdBits-1:0] running_job;
        logic [2:0]        running_priority;
        logic              switched;
        logic [4:0]        queue_count;
        logic              enqueue_rejected;
        logic [IdBits-1:0] assigned_job;
    } out_word_t;

    // One waiting task as held in a cell.
    typedef struct packed {
        logic [IdBits-1:0] id;
        logic [2:0]        base;
        logic [2:0]        cur;
        logic [7:0]        ticks;
    } entry_t;

    // Control word the sequencer broadcasts to every cell.
    typedef struct packed {
        logic       load;    // cell takes load_data
        logic       shift;   // cell takes the word of its right neighbour
        logic       age;     // cell increments and flags ageing
        logic [7:0] age_lim;
        logic [2:0] age_ceil;
    } cell_ctl_t;
endpackage
`default_nettype wire

/* hw/rtl/pjs_cell.sv */
// ---------------------------------------------------------------------------
// pjs_cell
// One slot of the wait queue: holds an entry and moves it left on shift.
// ---------------------------------------------------------------------------
`default_nettype none
module pjs_cell (
    input  wire logic             clk,
    input  wire pjs_pkg::cell_ctl_t ctl,
    input  wire logic             ld_sel,
    input  wire logic             sh_sel,
    input  wire pjs_pkg::entry_t  load_data,
    input  wire pjs_pkg::entry_t  right,
    output pjs_pkg::entry_t       word,
    output logic                  aged
);
    import pjs_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic [7:0] tk;

    // Saturating wait count and ageing decision. A cell picked for a load
    // takes the loaded entry even when the shift is active elsewhere.
    always_comb
    begin
        tk = (entry_reg.ticks == 8'hFF) ? entry_reg.ticks : entry_reg.ticks + 8'd1;
        aged = (tk >= ctl.age_lim) && (entry_reg.cur < ctl.age_ceil);
        entry_next = entry_reg;
        if (ctl.age)
        begin
            entry_next.ticks = aged ? 8'd0 : tk;
            if (aged)
            begin
                entry_next.cur = entry_reg.cur + 3'd1;
            end
        end
        else if (ctl.load && ld_sel)
        begin
            entry_next = load_data;
        end
        else if (ctl.shift && sh_sel)
        begin
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign word = entry_reg;
endmodule
`default_nettype wire

/* hw/rtl/priority_job_scheduler_with_aging_top.sv */
// With up to 16 waiting tasks, a tick, enqueue or dequeue holds busy while the
// queue is aged, rotated and scanned; done rises as busy falls, and a done mark
// goes straight to the output step. One word at a time; the next word is taken
// in the strobe cycle. The sequencer walks the cells one slot per cycle for
// rotation and search; ageing and the switch act on all cells at once. Reset
// clears the running slot, queue length and ID counter, resets the config; cells hold none.
`default_nettype none
module priority_job_scheduler_with_aging_top (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire pjs_pkg::in_word_t      in_word,
    output logic                        busy,
    output logic                        done,
    output pjs_pkg::out_word_t          out_word,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [7:0]             cfg_data
);
    import pjs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_AGE   = 7'b0000010,
        S_ROT   = 7'b0000100,
        S_OP    = 7'b0001000,
        S_FIND  = 7'b0010000,
        S_DROP  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;

    logic [7:0] q1_reg, q2_reg, q3_reg, alim_reg;
    logic [2:0] aceil_reg;

    logic [LenBits-1:0] len_reg;
    logic               rv_reg, fin_reg;
    logic [IdBits-1:0]  rid_reg, idc_reg;
    logic [2:0]         rbase_reg, rcur_reg;
    logic [7:0]         slice_reg;

    in_word_t           req_reg;
    logic [LenBits-1:0] cnt_reg;      // walk position
    logic [QueueDepth-1:0] aged_reg;  // flags captured at the ageing step
    logic [LenBits-1:0] nrot_reg;     // entries still to visit in the rotation walk
    logic               sw_reg, rej_reg, pre_reg, dq_reg;
    logic [IdBits-1:0]  asg_reg;
    logic               have_reg;
    logic [IdxBits-1:0] best_reg, drop_reg;
    logic               eq_reg;       // some waiting task has pri >= running
    logic               phase_reg;    // 0 dequeue search, 1 best search

    entry_t  words [QueueDepth];
    logic    aged  [QueueDepth];
    cell_ctl_t ctl;
    logic [QueueDepth-1:0] ld_sel, sh_sel, is_last;
    entry_t  load_data;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_reg <= 8'd5; q2_reg <= 8'd2; q3_reg <= 8'd1;
            alim_reg <= 8'd10; aceil_reg <= 3'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_QUANTUM1: q1_reg <= cfg_data;
                REG_QUANTUM2: q2_reg <= cfg_data;
                REG_QUANTUM3: q3_reg <= cfg_data;
                REG_AGE_LIM:  alim_reg <= cfg_data;
                REG_AGE_CEIL: aceil_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // The chain of cells; cell i shifts in the word of cell i+1.
    for (genvar g = 0; g < QueueDepth; g++)
    begin : g_cell
        entry_t rgt;
        if (g == QueueDepth - 1)
        begin : g_last
            assign rgt = words[g];
        end
        else
        begin : g_mid
            assign rgt = words[g+1];
        end
        pjs_cell u_cell (
            .clk(clk), .ctl(ctl), .ld_sel(ld_sel[g]), .sh_sel(sh_sel[g]),
            .load_data(load_data), .right(rgt), .word(words[g]), .aged(aged[g])
        );
    end

    // Helpers on the walk position.
    logic [IdxBits-1:0] pos;
    entry_t cur_e;
    logic expired;
    logic [LenBits-1:0] last;
    assign pos    = cnt_reg[IdxBits-1:0];
    assign cur_e  = words[pos];
    assign last   = len_reg - 1'b1;

    always_comb
    begin
        if (!rv_reg)
        begin
            expired = 1'b1;
        end
        else
        begin
            case (rcur_reg)
                3'd1: expired = slice_reg >= q1_reg;
                3'd2: expired = slice_reg >= q2_reg;
                3'd3: expired = slice_reg >= q3_reg;
                default: expired = 1'b1;
            endcase
        end
    end

    // Cell moves. Rotate, drop and switch all shift the cells from a start
    // slot up to len-2 one place left; rotate loads the moved entry and a switch
    // loads any displaced task into slot len-1, while an enqueue loads slot len.
    logic do_rot, do_enq, do_drop, do_swap, do_push;
    logic [IdxBits-1:0] from_idx;
    assign do_rot  = (state_reg == S_ROT) && (nrot_reg != '0) && aged_reg[pos];
    assign do_enq  = (state_reg == S_OP) && (req_reg.op == OP_ENQUEUE)
                  && (len_reg != LenBits'(QueueDepth));
    assign do_drop = (state_reg == S_DROP) && !phase_reg && dq_reg;
    assign do_swap = (state_reg == S_DROP) && phase_reg && dq_reg && have_reg;
    assign do_push = do_swap && rv_reg && !fin_reg;
    assign from_idx = do_rot ? pos : (do_drop ? drop_reg : best_reg);

    always_comb
    begin
        for (int i = 0; i < QueueDepth; i++)
        begin
            is_last[i] = (LenBits'(i) == last);
            sh_sel[i]  = (IdxBits'(i) >= from_idx) && (LenBits'(i) < last);
        end
        ld_sel = do_enq ? (QueueDepth'(1) << len_reg[IdxBits-1:0]) : is_last;
    end

    // Control word broadcast to the cells and the entry to load.
    always_comb
    begin
        ctl.age_lim  = alim_reg;
        ctl.age_ceil = aceil_reg;
        ctl.age   = (state_reg == S_AGE);
        ctl.load  = do_rot || do_enq || do_push;
        ctl.shift = do_rot || do_drop || do_swap;
        if (do_rot)
        begin
            load_data = cur_e;
        end
        else if (do_enq)
        begin
            load_data.id    = idc_reg + 1'b1;
            load_data.base  = req_reg.priority_req;
            load_data.cur   = req_reg.priority_req;
            load_data.ticks = 8'd0;
        end
        else
        begin
            load_data.id    = rid_reg;
            load_data.base  = rbase_reg;
            load_data.cur   = rbase_reg;
            load_data.ticks = 8'd0;
        end
    end

    // Sequencer and scalar state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg <= '0; rv_reg <= 1'b0; fin_reg <= 1'b0;
            rid_reg <= '0; idc_reg <= '0; rbase_reg <= '0; rcur_reg <= '0;
            slice_reg <= '0; done <= 1'b0; out_word <= '0;
            cnt_reg <= '0; aged_reg <= '0; nrot_reg <= '0;
            sw_reg <= 1'b0; rej_reg <= 1'b0; pre_reg <= 1'b0; dq_reg <= 1'b0;
            asg_reg <= '0; have_reg <= 1'b0; best_reg <= '0; drop_reg <= '0;
            eq_reg <= 1'b0; phase_reg <= 1'b0; req_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg <= in_word;
                        sw_reg <= 1'b0; rej_reg <= 1'b0; pre_reg <= 1'b0;
                        asg_reg <= '0;
                        if (in_word.op == OP_DONE)
                        begin
                            if (rv_reg)
                            begin
                                fin_reg <= 1'b1;
                            end
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_AGE;
                        end
                    end
                end
                S_AGE:
                begin
                    for (int i = 0; i < QueueDepth; i++)
                    begin
                        aged_reg[i] <= aged[i] && (LenBits'(i) < len_reg);
                    end
                    if (rv_reg && slice_reg != 8'hFF)
                    begin
                        slice_reg <= slice_reg + 8'd1;
                    end
                    cnt_reg <= '0;
                    nrot_reg <= len_reg;
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    // Walk the queue; each aged entry is rotated to the tail and the
                    // flags shift with the entries, so pos stays put.
                    if (nrot_reg == '0)
                    begin
                        state_reg <= S_OP;
                    end
                    else if (aged_reg[pos])
                    begin
                        aged_reg <= ((aged_reg >> 1) & sh_sel)
                                  | (aged_reg & ~sh_sel & ~is_last);
                        nrot_reg <= nrot_reg - 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        nrot_reg <= nrot_reg - 1'b1;
                    end
                end
                S_OP:
                begin
                    cnt_reg <= '0;
                    dq_reg <= 1'b0;
                    phase_reg <= 1'b0;
                    if (req_reg.op == OP_ENQUEUE)
                    begin
                        if (len_reg == LenBits'(QueueDepth))
                        begin
                            rej_reg <= 1'b1;
                        end
                        else
                        begin
                            idc_reg <= idc_reg + 1'b1;
                            asg_reg <= idc_reg + 1'b1;
                            len_reg <= len_reg + 1'b1;
                            pre_reg <= rv_reg && (req_reg.priority_req > rcur_reg);
                        end
                        phase_reg <= 1'b1;
                    end
                    else if (req_reg.op == OP_DEQUEUE && rv_reg
                             && rid_reg == req_reg.target_job)
                    begin
                        rv_reg <= 1'b0; fin_reg <= 1'b0; slice_reg <= '0;
                        sw_reg <= 1'b1;
                        phase_reg <= 1'b1;
                    end
                    else if (req_reg.op != OP_DEQUEUE)
                    begin
                        phase_reg <= 1'b1;
                    end
                    have_reg <= 1'b0; eq_reg <= 1'b0; best_reg <= '0;
                    state_reg <= S_FIND;
                end
                S_FIND:
                begin
                    // One entry per cycle: dequeue match or best/equal scan.
                    if (cnt_reg >= len_reg)
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_DROP;
                        dq_reg <= phase_reg ? (pre_reg || (expired && (eq_reg || !rv_reg)))
                                            : dq_reg;
                    end
                    else if (!phase_reg)
                    begin
                        if (cur_e.id == req_reg.target_job)
                        begin
                            dq_reg <= 1'b1; drop_reg <= pos;
                            cnt_reg <= len_reg;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (!have_reg || cur_e.cur > words[best_reg].cur)
                        begin
                            best_reg <= pos; have_reg <= 1'b1;
                        end
                        if (cur_e.cur >= rcur_reg)
                        begin
                            eq_reg <= 1'b1;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DROP:
                begin
                    if (!phase_reg)
                    begin
                        // Dequeue removal done; now run the switch scan.
                        if (dq_reg)
                        begin
                            len_reg <= len_reg - 1'b1;
                        end
                        dq_reg <= 1'b0; phase_reg <= 1'b1; cnt_reg <= '0;
                        have_reg <= 1'b0; eq_reg <= 1'b0; best_reg <= '0;
                        state_reg <= S_FIND;
                    end
                    else
                    begin
                        // Switch: a finished task is retired, the best waiting
                        // task takes the slot and any displaced task joins the
                        // tail in the same cycle as the cells close the gap.
                        if (dq_reg && have_reg)
                        begin
                            rv_reg <= 1'b1; fin_reg <= 1'b0; sw_reg <= 1'b1;
                            rid_reg <= words[best_reg].id;
                            rbase_reg <= words[best_reg].base;
                            rcur_reg <= words[best_reg].cur;
                            slice_reg <= '0;
                            if (!do_push)
                            begin
                                len_reg <= len_reg - 1'b1;
                            end
                        end
                        else if (dq_reg && rv_reg && fin_reg)
                        begin
                            rv_reg <= 1'b0; fin_reg <= 1'b0; sw_reg <= 1'b1;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    done <= 1'b1;
                    out_word.running_valid    <= rv_reg;
                    out_word.running_job      <= rv_reg ? rid_reg : '0;
                    out_word.running_priority <= rv_reg ? rcur_reg : '0;
                    out_word.switched         <= sw_reg;
                    out_word.queue_count      <= 5'(len_reg);
                    out_word.enqueue_rejected <= rej_reg;
                    out_word.assigned_job     <= asg_reg;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/pjs_checker.sv */
// ---------------------------------------------------------------------------
// pjs_checker
// Port-level checks of the job scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "priority_job_scheduler_with_aging_top_defines.svh"
module pjs_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire pjs_pkg::out_word_t out_word,
    input wire logic               cfg_ready
);
    import pjs_pkg::*;

    `PJS_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted word not busy")
    `PJS_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "done strobe longer than a cycle")
    `PJS_ASSERT_IMP(a_idle_job, clk, rst_n, done && !out_word.running_valid,
                    out_word.running_job == '0, "idle slot with a job")
    `PJS_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_ready, !busy, "config ready while busy")
endmodule

bind priority_job_scheduler_with_aging_top pjs_checker u_pjs_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .out_word(out_word), .cfg_ready(cfg_ready)
);
`default_nettype wire
